>>> sv/accel_to_attitude_command_top_macros.svh
// Assertion macros shared by the acceleration-to-attitude command block.
`ifndef ACCEL_TO_ATTITUDE_COMMAND_TOP_MACROS_SVH
`define ACCEL_TO_ATTITUDE_COMMAND_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define ATAC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons a fixed number of cycles after ante.
`define ATAC_ASSERT_AFTER(label, clk, rst, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

>>> sv/atac_pkg.sv
// Widths, register codes and reset values for the acceleration-to-attitude block.
`default_nettype none

package atac_pkg;

  // Fractional bits of the acceleration inputs.
  localparam int ACCEL_FRAC_BITS_DFLT = 8;

  localparam int IN_W       = 16;
  localparam int CMD_W      = 12;
  localparam int THR_W      = 12;
  localparam int GAIN_W     = 10;
  localparam int TILT_W     = 13;
  localparam int LIM_W      = 11;
  localparam int YGAIN_W    = 14;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Tilt divisor: 9.8 minus accel_z, signed, and its magnitude.
  localparam int DEN_W      = 18;
  localparam int DEN_MAG_W  = DEN_W - 1;
  // Magnitude of accel times tilt gain.
  localparam int NUM_W      = IN_W + TILT_W - 1;
  // Quotient bits kept by the divider; anything larger saturates.
  localparam int Q_W        = CMD_W;
  localparam int DIV_BITS_PER_STAGE_DFLT = 3;

  // Yaw product scale: gain in half units over Q1.12.
  localparam int YAW_SHIFT  = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRUST_HOVER  = 4'd0,
    REG_THRUST_GAIN   = 4'd1,
    REG_THRUST_UPPER  = 4'd2,
    REG_THRUST_LOWER  = 4'd3,
    REG_TILT_GAIN     = 4'd4,
    REG_COMMAND_LIMIT = 4'd5,
    REG_YAW_TARGET    = 4'd6,
    REG_YAW_GAIN      = 4'd7
  } cfg_reg_t;

  localparam logic [THR_W-1:0]          THRUST_HOVER_RST  = 12'd1830;
  localparam logic [GAIN_W-1:0]         THRUST_GAIN_RST   = 10'd165;
  localparam logic [THR_W-1:0]          THRUST_UPPER_RST  = 12'd2400;
  localparam logic [THR_W-1:0]          THRUST_LOWER_RST  = 12'd1700;
  localparam logic [TILT_W-1:0]         TILT_GAIN_RST     = 13'd2200;
  localparam logic [LIM_W-1:0]          COMMAND_LIMIT_RST = 11'd1500;
  localparam logic signed [IN_W-1:0]    YAW_TARGET_RST    = 16'sd0;
  localparam logic signed [YGAIN_W-1:0] YAW_GAIN_RST      = -14'sd2151;

endpackage

`default_nettype wire

>>> sv/atac_div.sv
// Pipelined restoring divider on magnitudes, BITS_PER_STAGE quotient bits per stage.
`default_nettype none

module atac_div #(
  parameter int NUM_W          = atac_pkg::NUM_W,
  parameter int DEN_W          = atac_pkg::DEN_MAG_W,
  parameter int Q_W            = atac_pkg::Q_W,
  parameter int BITS_PER_STAGE = atac_pkg::DIV_BITS_PER_STAGE_DFLT
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  localparam int STAGES = (Q_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int RW     = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [RW-1:0]    rem_q    [0:STAGES-2];
  logic [DEN_W-1:0] den_q    [0:STAGES-2];
  logic [Q_W-1:0]   quo_q    [0:STAGES-1];
  logic             ovf_q    [0:STAGES-1];

  logic [RW-1:0]    rem_in   [0:STAGES-1];
  logic [DEN_W-1:0] den_in   [0:STAGES-1];
  logic [Q_W-1:0]   quo_in   [0:STAGES-1];
  logic [RW-1:0]    rem_next [0:STAGES-1];
  logic [Q_W-1:0]   quo_next [0:STAGES-1];

  always_comb begin : p_feed
    rem_in[0] = RW'(num);
    den_in[0] = den;
    quo_in[0] = '0;
    for (int s = 1; s < STAGES; s++) begin
      rem_in[s] = rem_q[s-1];
      den_in[s] = den_q[s-1];
      quo_in[s] = quo_q[s-1];
    end
  end

  // Each stage tries its quotient bits MSB first and shifts them in.
  always_comb begin : p_steps
    logic [RW-1:0]  r;
    logic [RW-1:0]  sh;
    logic [Q_W-1:0] q;
    for (int s = 0; s < STAGES; s++) begin
      r  = rem_in[s];
      q  = quo_in[s];
      sh = '0;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        if (s * BITS_PER_STAGE + j < Q_W) begin
          sh = RW'(den_in[s]) << (Q_W - 1 - s * BITS_PER_STAGE - j);
          if (r >= sh) begin
            r = r - sh;
            q = {q[Q_W-2:0], 1'b1};
          end else begin
            q = {q[Q_W-2:0], 1'b0};
          end
        end
      end
      rem_next[s] = r;
      quo_next[s] = q;
    end
  end

  always_ff @(posedge clk) begin
    // quotient would not fit in Q_W bits
    ovf_q[0] <= RW'(num) >= (RW'(den) << Q_W);
    for (int s = 1; s < STAGES; s++) begin
      ovf_q[s] <= ovf_q[s-1];
    end
    for (int s = 0; s < STAGES; s++) begin
      quo_q[s] <= quo_next[s];
    end
    for (int s = 0; s < STAGES - 1; s++) begin
      rem_q[s] <= rem_next[s];
      den_q[s] <= den_in[s];
    end
  end

  assign quo = quo_q[STAGES-1];
  assign ovf = ovf_q[STAGES-1];

endmodule

`default_nettype wire

>>> sv/accel_to_attitude_command_top.sv
// Top level: acceleration and yaw to clamped thrust, roll, pitch and yaw commands.
//
// Channel   Ports                                         Transfer
// request   start, busy, accel_x/y/z, yaw_angle           start && !busy
// result    done, thrust/roll/pitch/yaw_cmd, divide_fault done strobe, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data     cfg_valid && cfg_ready
//
// One request is taken every cycle while busy is low; its result strobes on done
// after passing stage 1, stage 2, the divider stages and the output register.
// The roll and pitch dividers are restoring dividers with one register per stage.
// Reset reloads the register defaults and clears every valid bit; busy follows rst.
// Nothing stalls: results cannot be held off and cfg_ready is always high.
`default_nettype none

module accel_to_attitude_command_top #(
  parameter int ACCEL_FRAC_BITS    = atac_pkg::ACCEL_FRAC_BITS_DFLT,
  parameter int DIV_BITS_PER_STAGE = atac_pkg::DIV_BITS_PER_STAGE_DFLT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [atac_pkg::IN_W-1:0]     accel_x,
  input  logic signed [atac_pkg::IN_W-1:0]     accel_y,
  input  logic signed [atac_pkg::IN_W-1:0]     accel_z,
  input  logic signed [atac_pkg::IN_W-1:0]     yaw_angle,
  output logic                                 done,
  output logic        [atac_pkg::THR_W-1:0]    thrust_cmd,
  output logic signed [atac_pkg::CMD_W-1:0]    roll_cmd,
  output logic signed [atac_pkg::CMD_W-1:0]    pitch_cmd,
  output logic signed [atac_pkg::CMD_W-1:0]    yaw_cmd,
  output logic                                 divide_fault,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [atac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [atac_pkg::CFG_DATA_W-1:0] cfg_data
);

  import atac_pkg::*;

  localparam int DIV_STAGES = (Q_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
  localparam int LATENCY    = DIV_STAGES + 3;

  localparam int AW  = IN_W + 1;                 // negated or differenced input
  localparam int NPW = AW + TILT_W + 1;          // tilt product
  localparam int TPW = AW + GAIN_W + 1;          // thrust product
  localparam int HW  = THR_W + 1 + ACCEL_FRAC_BITS;
  localparam int TSW = ((TPW > HW) ? TPW : HW) + 1;
  localparam int TTW = TSW - ACCEL_FRAC_BITS;    // thrust after scaling
  localparam int YPW = AW + YGAIN_W;             // yaw product
  localparam int YTW = YPW - YAW_SHIFT;          // yaw after scaling

  // 9.8 in the acceleration format, rounded to nearest
  localparam int                       K98   = (98 * (1 << ACCEL_FRAC_BITS) + 5) / 10;
  localparam logic signed [DEN_W-1:0]  K_DEN = DEN_W'(K98);
  localparam logic signed [TSW-1:0]    T_RND = TSW'((1 << ACCEL_FRAC_BITS) - 1);
  localparam logic signed [YPW-1:0]    Y_RND = YPW'((1 << YAW_SHIFT) - 1);

  typedef struct packed {
    logic                   fault;
    logic                   roll_neg;
    logic                   pitch_neg;
    logic signed [TTW-1:0]  thrust;
    logic signed [YTW-1:0]  yaw;
  } side_t;

  // configuration registers
  logic        [THR_W-1:0]   thrust_hover;
  logic        [GAIN_W-1:0]  thrust_gain;
  logic        [THR_W-1:0]   thrust_upper;
  logic        [THR_W-1:0]   thrust_lower;
  logic        [TILT_W-1:0]  tilt_gain;
  logic        [LIM_W-1:0]   command_limit;
  logic signed [IN_W-1:0]    yaw_target;
  logic signed [YGAIN_W-1:0] yaw_gain;

  logic accept;

  // stage 1
  logic                    s1_valid;
  logic signed [NUM_W:0]   s1_num_r;
  logic signed [NUM_W:0]   s1_num_p;
  logic signed [DEN_W-1:0] s1_den;
  logic signed [TPW-1:0]   s1_tprod;
  logic signed [YPW-1:0]   s1_yprod;

  // stage 2
  logic                    s2_valid;
  logic [NUM_W-1:0]        s2_mag_r;
  logic [NUM_W-1:0]        s2_mag_p;
  logic [DEN_MAG_W-1:0]    s2_mag_d;
  side_t                   s2_side;

  // sideband alongside the dividers
  logic                    vld_q [1:DIV_STAGES];
  side_t                   sb_q  [1:DIV_STAGES];

  logic [Q_W-1:0]          quo_r;
  logic [Q_W-1:0]          quo_p;
  logic                    ovf_r;
  logic                    ovf_p;

  // stage 1 products
  logic signed [AW-1:0]    ax_neg;
  logic signed [AW-1:0]    ay_neg;
  logic signed [AW-1:0]    az_neg;
  logic signed [AW-1:0]    yaw_err;
  logic signed [NPW-1:0]   prod_r;
  logic signed [NPW-1:0]   prod_p;

  // stage 2 scaling
  logic signed [NUM_W:0]   neg_r;
  logic signed [NUM_W:0]   neg_p;
  logic signed [DEN_W-1:0] neg_d;
  logic signed [TSW-1:0]   t_sum;
  logic signed [TSW-1:0]   t_adj;
  logic signed [TSW-1:0]   t_shr;
  logic signed [YPW-1:0]   y_adj;
  logic signed [YPW-1:0]   y_shr;

  // output stage
  logic signed [TTW-1:0]   t_up;
  logic signed [TTW-1:0]   t_lo;
  logic signed [TTW-1:0]   t_c1;
  logic signed [TTW-1:0]   t_c2;
  logic signed [YTW-1:0]   y_lim;
  logic signed [YTW-1:0]   y_c1;
  logic signed [YTW-1:0]   y_c2;
  logic        [THR_W-1:0] thrust_next;
  logic signed [CMD_W-1:0] roll_next;
  logic signed [CMD_W-1:0] pitch_next;
  logic signed [CMD_W-1:0] yaw_next;

  function automatic logic signed [CMD_W-1:0] tilt_cmd(
    input logic [Q_W-1:0]   q,
    input logic             ovf,
    input logic             neg,
    input logic             fault,
    input logic [LIM_W-1:0] lim
  );
    logic [Q_W-1:0]          mag;
    logic signed [CMD_W-1:0] sm;
    mag = (ovf || q > Q_W'(lim)) ? Q_W'(lim) : q;
    sm  = $signed(CMD_W'(mag));
    if (fault) begin
      return '0;
    end
    return neg ? -sm : sm;
  endfunction

  // refuse requests while the pipeline clears
  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      thrust_hover  <= THRUST_HOVER_RST;
      thrust_gain   <= THRUST_GAIN_RST;
      thrust_upper  <= THRUST_UPPER_RST;
      thrust_lower  <= THRUST_LOWER_RST;
      tilt_gain     <= TILT_GAIN_RST;
      command_limit <= COMMAND_LIMIT_RST;
      yaw_target    <= YAW_TARGET_RST;
      yaw_gain      <= YAW_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRUST_HOVER:  thrust_hover  <= cfg_data[THR_W-1:0];
        REG_THRUST_GAIN:   thrust_gain   <= cfg_data[GAIN_W-1:0];
        REG_THRUST_UPPER:  thrust_upper  <= cfg_data[THR_W-1:0];
        REG_THRUST_LOWER:  thrust_lower  <= cfg_data[THR_W-1:0];
        REG_TILT_GAIN:     tilt_gain     <= cfg_data[TILT_W-1:0];
        REG_COMMAND_LIMIT: command_limit <= cfg_data[LIM_W-1:0];
        REG_YAW_TARGET:    yaw_target    <= cfg_data[IN_W-1:0];
        REG_YAW_GAIN:      yaw_gain      <= cfg_data[YGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- stage 1: products ----
  assign ax_neg  = -AW'(accel_x);
  assign ay_neg  = -AW'(accel_y);
  assign az_neg  = -AW'(accel_z);
  assign yaw_err = AW'(yaw_angle) - AW'(yaw_target);
  assign prod_r  = NPW'(ay_neg) * NPW'($signed({1'b0, tilt_gain}));
  assign prod_p  = NPW'(ax_neg) * NPW'($signed({1'b0, tilt_gain}));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_num_r <= prod_r[NUM_W:0];
    s1_num_p <= prod_p[NUM_W:0];
    s1_den   <= K_DEN - DEN_W'(accel_z);
    s1_tprod <= TPW'(az_neg) * TPW'($signed({1'b0, thrust_gain}));
    s1_yprod <= YPW'(yaw_err) * YPW'(yaw_gain);
  end

  // ---- stage 2: magnitudes, signs, scaling toward zero ----
  assign neg_r = -s1_num_r;
  assign neg_p = -s1_num_p;
  assign neg_d = -s1_den;
  assign t_sum = TSW'(s1_tprod) + TSW'($signed({1'b0, thrust_hover, {ACCEL_FRAC_BITS{1'b0}}}));
  assign t_adj = t_sum + (t_sum[TSW-1] ? T_RND : TSW'(0));
  assign t_shr = t_adj >>> ACCEL_FRAC_BITS;
  assign y_adj = s1_yprod + (s1_yprod[YPW-1] ? Y_RND : YPW'(0));
  assign y_shr = y_adj >>> YAW_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_mag_r          <= s1_num_r[NUM_W] ? neg_r[NUM_W-1:0] : s1_num_r[NUM_W-1:0];
    s2_mag_p          <= s1_num_p[NUM_W] ? neg_p[NUM_W-1:0] : s1_num_p[NUM_W-1:0];
    s2_mag_d          <= s1_den[DEN_W-1] ? neg_d[DEN_MAG_W-1:0] : s1_den[DEN_MAG_W-1:0];
    s2_side.fault     <= (s1_den == '0);
    s2_side.roll_neg  <= s1_num_r[NUM_W] ^ s1_den[DEN_W-1];
    s2_side.pitch_neg <= s1_num_p[NUM_W] ^ s1_den[DEN_W-1];
    s2_side.thrust    <= t_shr[TTW-1:0];
    s2_side.yaw       <= y_shr[YTW-1:0];
  end

  // ---- divider stages ----
  atac_div #(
    .NUM_W          (NUM_W),
    .DEN_W          (DEN_MAG_W),
    .Q_W            (Q_W),
    .BITS_PER_STAGE (DIV_BITS_PER_STAGE)
  ) u_div_roll (
    .clk (clk),
    .num (s2_mag_r),
    .den (s2_mag_d),
    .quo (quo_r),
    .ovf (ovf_r)
  );

  atac_div #(
    .NUM_W          (NUM_W),
    .DEN_W          (DEN_MAG_W),
    .Q_W            (Q_W),
    .BITS_PER_STAGE (DIV_BITS_PER_STAGE)
  ) u_div_pitch (
    .clk (clk),
    .num (s2_mag_p),
    .den (s2_mag_d),
    .quo (quo_p),
    .ovf (ovf_p)
  );

  // advance the sideband in step with the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= DIV_STAGES; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[1] <= s2_valid;
      for (int k = 2; k <= DIV_STAGES; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    sb_q[1] <= s2_side;
    for (int k = 2; k <= DIV_STAGES; k++) begin
      sb_q[k] <= sb_q[k-1];
    end
  end

  // ---- output stage: clamp ----
  assign t_up  = TTW'($signed({1'b0, thrust_upper}));
  assign t_lo  = TTW'($signed({1'b0, thrust_lower}));
  assign y_lim = YTW'($signed({1'b0, command_limit}));

  always_comb begin
    // upper bound first, lower bound wins when the two cross
    t_c1        = ($signed(sb_q[DIV_STAGES].thrust) >= t_up) ? t_up
                                                            : sb_q[DIV_STAGES].thrust;
    t_c2        = (t_c1 <= t_lo) ? t_lo : t_c1;
    thrust_next = t_c2[THR_W-1:0];

    y_c1     = ($signed(sb_q[DIV_STAGES].yaw) >= y_lim) ? y_lim : sb_q[DIV_STAGES].yaw;
    y_c2     = (y_c1 <= -y_lim) ? -y_lim : y_c1;
    yaw_next = y_c2[CMD_W-1:0];

    roll_next  = tilt_cmd(quo_r, ovf_r, sb_q[DIV_STAGES].roll_neg,
                          sb_q[DIV_STAGES].fault, command_limit);
    pitch_next = tilt_cmd(quo_p, ovf_p, sb_q[DIV_STAGES].pitch_neg,
                          sb_q[DIV_STAGES].fault, command_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    thrust_cmd   <= thrust_next;
    roll_cmd     <= roll_next;
    pitch_cmd    <= pitch_next;
    yaw_cmd      <= yaw_next;
    divide_fault <= sb_q[DIV_STAGES].fault;
  end

  // ---- checks ----
`include "accel_to_attitude_command_top_macros.svh"

  `ATAC_ASSERT_AFTER(a_latency, clk, rst, accept, LATENCY, done, "result strobe missing after request")
  `ATAC_ASSERT_NOW(a_fault_zero, clk, rst, done && divide_fault, roll_cmd == '0 && pitch_cmd == '0, "tilt commands not zero on divide fault")
  `ATAC_ASSERT_NOW(a_thrust_bounds, clk, rst, done && thrust_lower <= thrust_upper, thrust_cmd >= thrust_lower && thrust_cmd <= thrust_upper, "thrust outside its bounds")
  `ATAC_ASSERT_NOW(a_yaw_limit, clk, rst, done, yaw_cmd <= $signed({1'b0, command_limit}) && yaw_cmd >= -$signed({1'b0, command_limit}), "yaw command beyond limit")

endmodule

`default_nettype wire

>>> tb/accel_to_attitude_command_top_tb.sv
// Self-checking testbench for the acceleration-to-attitude command block.
`timescale 1ns / 100ps

module accel_to_attitude_command_top_tb;
  import atac_pkg::*;

  localparam longint ACCEL_ONE   = longint'(1) << ACCEL_FRAC_BITS_DFLT;
  // 9.8 m/s^2 in the acceleration format, rounded to nearest
  localparam longint GRAVITY_Q   = (98 * ACCEL_ONE + 5) / 10;
  localparam longint YAW_SCALE   = longint'(1) << YAW_SHIFT;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     CYCLE_LIMIT   = 500000;
  localparam int     RANDOM_PHASES = 6;
  localparam int     PHASE_ITEMS   = 325;

  typedef struct packed {
    logic [THR_W-1:0] thrust;
    logic [CMD_W-1:0] roll;
    logic [CMD_W-1:0] pitch;
    logic [CMD_W-1:0] yaw;
    logic             fault;
  } attitude_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [IN_W-1:0] accel_x = '0;
  logic signed [IN_W-1:0] accel_y = '0;
  logic signed [IN_W-1:0] accel_z = '0;
  logic signed [IN_W-1:0] yaw_angle = '0;
  logic done;
  logic [THR_W-1:0] thrust_cmd;
  logic signed [CMD_W-1:0] roll_cmd;
  logic signed [CMD_W-1:0] pitch_cmd;
  logic signed [CMD_W-1:0] yaw_cmd;
  logic divide_fault;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies used for prediction
  logic [THR_W-1:0]          hover_setting       = THRUST_HOVER_RST;
  logic [GAIN_W-1:0]         thrust_gain_setting = THRUST_GAIN_RST;
  logic [THR_W-1:0]          upper_setting       = THRUST_UPPER_RST;
  logic [THR_W-1:0]          lower_setting       = THRUST_LOWER_RST;
  logic [TILT_W-1:0]         tilt_setting        = TILT_GAIN_RST;
  logic [LIM_W-1:0]          limit_setting       = COMMAND_LIMIT_RST;
  logic signed [IN_W-1:0]    yaw_target_setting  = YAW_TARGET_RST;
  logic signed [YGAIN_W-1:0] yaw_gain_setting    = YAW_GAIN_RST;

  attitude_cmd_t expected_cmds[$];
  int errors = 0;
  int cycle_count = 0;

  accel_to_attitude_command_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .yaw_angle    (yaw_angle),
    .done         (done),
    .thrust_cmd   (thrust_cmd),
    .roll_cmd     (roll_cmd),
    .pitch_cmd    (pitch_cmd),
    .yaw_cmd      (yaw_cmd),
    .divide_fault (divide_fault),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint clamp_symmetric(input longint v, input longint lim);
    longint r;
    r = v;
    if (r >= lim) r = lim;
    if (r <= -lim) r = -lim;
    return r;
  endfunction

  function automatic attitude_cmd_t predict_commands(input logic signed [IN_W-1:0] ax,
                                                     input logic signed [IN_W-1:0] ay,
                                                     input logic signed [IN_W-1:0] az,
                                                     input logic signed [IN_W-1:0] psi);
    longint lim;
    longint thrust;
    longint den;
    longint roll;
    longint pitch;
    longint yaw;
    attitude_cmd_t c;
    lim = longint'(limit_setting);
    thrust = (longint'(thrust_gain_setting) * -longint'(az)
              + longint'(hover_setting) * ACCEL_ONE) / ACCEL_ONE;
    // upper bound first, so inverted bounds settle on the lower one
    if (thrust >= longint'(upper_setting)) thrust = longint'(upper_setting);
    if (thrust <= longint'(lower_setting)) thrust = longint'(lower_setting);
    den = GRAVITY_Q - longint'(az);
    if (den == 0) begin
      roll = 0;
      pitch = 0;
      c.fault = 1'b1;
    end else begin
      roll = clamp_symmetric(-longint'(ay) * longint'(tilt_setting) / den, lim);
      pitch = clamp_symmetric(-longint'(ax) * longint'(tilt_setting) / den, lim);
      c.fault = 1'b0;
    end
    yaw = clamp_symmetric(longint'(yaw_gain_setting)
                          * (longint'(psi) - longint'(yaw_target_setting)) / YAW_SCALE, lim);
    c.thrust = thrust[THR_W-1:0];
    c.roll = roll[CMD_W-1:0];
    c.pitch = pitch[CMD_W-1:0];
    c.yaw = yaw[CMD_W-1:0];
    return c;
  endfunction

  function automatic void store_register(input logic [CFG_IDX_W-1:0] index,
                                         input logic [CFG_DATA_W-1:0] data);
    case (index)
      REG_THRUST_HOVER:  hover_setting = data[THR_W-1:0];
      REG_THRUST_GAIN:   thrust_gain_setting = data[GAIN_W-1:0];
      REG_THRUST_UPPER:  upper_setting = data[THR_W-1:0];
      REG_THRUST_LOWER:  lower_setting = data[THR_W-1:0];
      REG_TILT_GAIN:     tilt_setting = data[TILT_W-1:0];
      REG_COMMAND_LIMIT: limit_setting = data[LIM_W-1:0];
      REG_YAW_TARGET:    yaw_target_setting = data[IN_W-1:0];
      REG_YAW_GAIN:      yaw_gain_setting = data[YGAIN_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [CMD_W-1:0] want,
                             input logic [CMD_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%03h, actual 0x%03h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    attitude_cmd_t want;
    if (!rst && done === 1'b1) begin
      if (expected_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual thrust 0x%03h", $time,
                 thrust_cmd);
      end else begin
        want = expected_cmds.pop_front();
        check_field("thrust_cmd", want.thrust, thrust_cmd);
        check_field("roll_cmd", want.roll, roll_cmd);
        check_field("pitch_cmd", want.pitch, pitch_cmd);
        check_field("yaw_cmd", want.yaw, yaw_cmd);
        check_field("divide_fault", CMD_W'(want.fault), CMD_W'(divide_fault));
      end
    end
  end

  // Hold start high; the caller lowers it when the burst ends.
  task automatic send_request(input logic signed [IN_W-1:0] ax, input logic signed [IN_W-1:0] ay,
                              input logic signed [IN_W-1:0] az,
                              input logic signed [IN_W-1:0] psi);
    start <= 1'b1;
    accel_x <= ax;
    accel_y <= ay;
    accel_z <= az;
    yaw_angle <= psi;
    do @(posedge clk); while (busy !== 1'b0);
    expected_cmds.push_back(predict_commands(ax, ay, az, psi));
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_cmds.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    store_register(index, data);
  endtask

  task automatic program_registers(input logic [CFG_DATA_W-1:0] hover,
                                   input logic [CFG_DATA_W-1:0] gain,
                                   input logic [CFG_DATA_W-1:0] upper,
                                   input logic [CFG_DATA_W-1:0] lower,
                                   input logic [CFG_DATA_W-1:0] tilt,
                                   input logic [CFG_DATA_W-1:0] limit,
                                   input logic [CFG_DATA_W-1:0] target,
                                   input logic [CFG_DATA_W-1:0] ygain);
    wait_drained();
    cfg_write(REG_THRUST_HOVER, hover);
    cfg_write(REG_THRUST_GAIN, gain);
    cfg_write(REG_THRUST_UPPER, upper);
    cfg_write(REG_THRUST_LOWER, lower);
    cfg_write(REG_TILT_GAIN, tilt);
    cfg_write(REG_COMMAND_LIMIT, limit);
    cfg_write(REG_YAW_TARGET, target);
    cfg_write(REG_YAW_GAIN, ygain);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] random_accel();
    case ($urandom_range(0, 3))
      0: return IN_W'($urandom);
      1: return IN_W'($urandom_range(0, 4095)) - IN_W'(2048);
      2: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      default: return IN_W'($urandom_range(0, 16383)) - IN_W'(8192);
    endcase
  endfunction

  task automatic send_random();
    logic signed [IN_W-1:0] az;
    logic signed [IN_W-1:0] psi;
    az = random_accel();
    // steer some requests onto or next to a zero tilt divisor
    if ($urandom_range(0, 15) == 0)
      az = IN_W'(GRAVITY_Q) + IN_W'($urandom_range(0, 4)) - IN_W'(2);
    if ($urandom_range(0, 1) != 0)
      psi = IN_W'($urandom);
    else
      psi = yaw_target_setting + IN_W'($urandom_range(0, 8191)) - IN_W'(4096);
    send_request(random_accel(), random_accel(), az, psi);
  endtask

  task automatic test_field_extremes();
    send_request(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_request(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_request(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_request(16'sd256, -16'sd256, -16'sd256, 16'sd4096);
    send_request(-16'sd1, 16'sd1, 16'sd1, -16'sd1);
    send_request(16'sd12345, -16'sd23456, -16'sd5000, -16'sd20000);
    hold_off(3);
  endtask

  task automatic test_zero_divisor();
    send_request(16'sd1000, -16'sd1000, IN_W'(GRAVITY_Q), 16'sd0);
    hold_off(1);
    send_request(16'sh8000, 16'sh7fff, IN_W'(GRAVITY_Q), 16'sd100);
    // divisor of plus and minus one
    send_request(16'sd500, 16'sd500, IN_W'(GRAVITY_Q - 1), 16'sd0);
    send_request(16'sd500, -16'sd500, IN_W'(GRAVITY_Q + 1), 16'sd0);
    hold_off(2);
  endtask

  task automatic test_register_extremes();
    program_registers(16'd4095, 16'd1023, 16'd4095, 16'd0, 16'd8191, 16'd2047,
                      16'h7fff, 16'd8191);
    send_request(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(-16'sd300, 16'sd300, 16'sd300, 16'sh7fff);
    send_request(16'sd0, 16'sd0, IN_W'(GRAVITY_Q), 16'sd0);
    program_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_request(-16'sd300, 16'sd300, 16'sd300, 16'sd0);
    // inverted thrust bounds and a zero command limit
    program_registers(16'd2000, 16'd500, 16'd100, 16'd3000, 16'd4000, 16'd0,
                      16'h8000, 16'h2000);
    send_request(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_request(-16'sd300, 16'sd300, 16'sd300, 16'sh8000);
    send_request(16'sd1, -16'sd1, 16'sh7fff, 16'sd0);
    hold_off(1);
  endtask

  task automatic test_register_write_rules();
    // bits above each register's width are dropped
    program_registers(16'hffff, 16'hffff, 16'hffff, 16'hf123, 16'hffff, 16'hffff,
                      16'hffff, 16'hdfff);
    // writes to unused indexes must leave every register untouched
    cfg_write(CFG_IDX_W'($urandom_range(REG_YAW_GAIN + 1, (1 << CFG_IDX_W) - 1)), 16'h0000);
    cfg_write(CFG_IDX_W'((1 << CFG_IDX_W) - 1), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_request(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
    send_request(-16'sd300, 16'sd300, 16'sd300, 16'sh7fff);
    send_request(16'sd700, -16'sd900, -16'sd200, 16'sd1000);
    hold_off(1);
  endtask

  task automatic test_random_traffic();
    int unsigned burst;
    int sent;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 3)
        0: program_registers(CFG_DATA_W'(THRUST_HOVER_RST), CFG_DATA_W'(THRUST_GAIN_RST),
                             CFG_DATA_W'(THRUST_UPPER_RST), CFG_DATA_W'(THRUST_LOWER_RST),
                             CFG_DATA_W'(TILT_GAIN_RST), CFG_DATA_W'(COMMAND_LIMIT_RST),
                             CFG_DATA_W'(YAW_TARGET_RST), CFG_DATA_W'(YAW_GAIN_RST));
        1: program_registers(CFG_DATA_W'($urandom_range(0, 4095)),
                             CFG_DATA_W'($urandom_range(0, 1023)),
                             CFG_DATA_W'($urandom_range(2048, 4095)),
                             CFG_DATA_W'($urandom_range(0, 2047)),
                             CFG_DATA_W'($urandom_range(0, 8191)),
                             CFG_DATA_W'($urandom_range(1, 2047)),
                             CFG_DATA_W'($urandom),
                             CFG_DATA_W'($urandom_range(0, 16383)));
        default: program_registers(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
        repeat (burst) begin
          if (sent < PHASE_ITEMS) begin
            send_random();
            sent++;
          end
        end
        // now and then let the pipeline empty before carrying on
        if ($urandom_range(0, 24) == 0)
          wait_drained();
        else
          hold_off($urandom_range(1, 9));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_zero_divisor();
    test_register_extremes();
    test_register_write_rules();
    test_random_traffic();
    wait_drained();
    if (errors == 0 && expected_cmds.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/atac_pkg.sv
sv/atac_div.sv
sv/accel_to_attitude_command_top.sv
tb/accel_to_attitude_command_top_tb.sv
